@@ rtl/core/pud_pkg.sv @@
package pud_pkg;

  localparam logic [7:0] PCT_CHAR   = 8'h25;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [3:0] HEX_TEN    = 4'd10;

  typedef enum logic [1:0] {
    ST_DATA = 2'd0,
    ST_DONE = 2'd1,
    ST_FAIL = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    status_t     status;
    logic [15:0] out_count;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0]        num;
    result_t [2:0]     entry;
  } bundle_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.bad   = 1'b0;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h61) + HEX_TEN;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h41) + HEX_TEN;
    end else begin
      h.bad = 1'b1;
    end
    return h;
  endfunction

  function automatic logic [7:0] plain_byte(input logic [7:0] c);
    return (c == PLUS_CHAR) ? SPACE_CHAR : c;
  endfunction

  function automatic result_t data_result(input logic [7:0] b);
    result_t r;
    r.out_byte    = b;
    r.status      = ST_DATA;
    r.out_count   = 16'd0;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  function automatic result_t end_result(input status_t st, input logic [15:0] cnt);
    result_t r;
    r.out_byte    = 8'd0;
    r.status      = st;
    r.out_count   = cnt;
    r.last_of_run = 1'b1;
    return r;
  endfunction

endpackage

@@ rtl/core/pud_in_if.sv @@
interface pud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

@@ rtl/core/pud_out_if.sv @@
interface pud_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [1:0]  status;
  logic [15:0] out_count;
  logic        last_of_run;

  modport source (output valid, output out_byte, output status, output out_count,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input status, input out_count,
                  input last_of_run, output ready);
endinterface

@@ rtl/core/pud_decode.sv @@
module pud_decode #(
  parameter int COUNT_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_data,
  input  logic             fire,
  input  logic [7:0]       in_byte,
  input  logic             end_of_string,
  output pud_pkg::bundle_t bundle
);
  import pud_pkg::*;

  localparam int CW = COUNT_BITS + 17;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_FIRST = 2'd2,
    PH_DRAIN = 2'd3
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [7:0]            held_r, held_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [15:0]           cap_r;

  logic [COUNT_BITS-1:0] cnt1, cnt2;
  logic                  room0, room1;
  logic [COUNT_BITS+15:0] ext0, ext1, ext2;
  hex_t                  hi, lo;

  always_comb begin
    cnt1  = count_r + COUNT_BITS'(1);
    cnt2  = cnt1 + COUNT_BITS'(1);
    room0 = (CW'(count_r) + CW'(1)) < CW'(cap_r);
    room1 = (CW'(cnt1) + CW'(1)) < CW'(cap_r);
    ext0  = {16'd0, count_r};
    ext1  = {16'd0, cnt1};
    ext2  = {16'd0, cnt2};
    hi    = hex_digit(held_r);
    lo    = hex_digit(in_byte);
  end

  always_comb begin
    phase_nxt    = phase_r;
    held_nxt     = held_r;
    count_nxt    = count_r;
    bundle.num   = 2'd0;
    bundle.entry = '0;
    if (phase_r == PH_DRAIN) begin
      if (end_of_string) begin
        phase_nxt = PH_IDLE;
        held_nxt  = 8'd0;
        count_nxt = '0;
      end
    end else if (end_of_string) begin
      phase_nxt = PH_IDLE;
      held_nxt  = 8'd0;
      count_nxt = '0;
      unique case (phase_r)
        PH_PCT: begin
          bundle.num      = 2'd2;
          bundle.entry[0] = data_result(PCT_CHAR);
          bundle.entry[1] = end_result(ST_DONE, ext1[15:0]);
        end
        PH_FIRST: begin
          bundle.entry[0] = data_result(PCT_CHAR);
          if (!room1) begin
            bundle.num      = 2'd2;
            bundle.entry[1] = end_result(ST_FAIL, 16'd0);
          end else begin
            bundle.num      = 2'd3;
            bundle.entry[1] = data_result(plain_byte(held_r));
            bundle.entry[2] = end_result(ST_DONE, ext2[15:0]);
          end
        end
        default: begin
          bundle.num      = 2'd1;
          bundle.entry[0] = end_result(ST_DONE, ext0[15:0]);
        end
      endcase
    end else begin
      unique case (phase_r)
        PH_PCT: begin
          held_nxt  = in_byte;
          phase_nxt = PH_FIRST;
        end
        PH_FIRST: begin
          bundle.num = 2'd1;
          held_nxt   = 8'd0;
          if (hi.bad || lo.bad) begin
            bundle.entry[0] = end_result(ST_FAIL, 16'd0);
            phase_nxt       = PH_DRAIN;
            count_nxt       = '0;
          end else begin
            bundle.entry[0] = data_result({hi.value, lo.value});
            phase_nxt       = PH_IDLE;
            count_nxt       = cnt1;
          end
        end
        default: begin
          if (!room0) begin
            bundle.num      = 2'd1;
            bundle.entry[0] = end_result(ST_FAIL, 16'd0);
            phase_nxt       = PH_DRAIN;
            held_nxt        = 8'd0;
            count_nxt       = '0;
          end else if (in_byte == PCT_CHAR) begin
            phase_nxt = PH_PCT;
          end else begin
            bundle.num      = 2'd1;
            bundle.entry[0] = data_result(plain_byte(in_byte));
            count_nxt       = cnt1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= 8'd0;
      count_r <= '0;
      cap_r   <= 16'd256;
    end else begin
      if (fire) begin
        phase_r <= phase_nxt;
        held_r  <= held_nxt;
        count_r <= count_nxt;
      end
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
    end
  end

endmodule

@@ rtl/core/pud_outq.sv @@
module pud_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  pud_pkg::bundle_t bundle,
  output logic             can_load,
  pud_out_if.source        out_if
);
  import pud_pkg::*;

  logic [1:0]    num_r, num_nxt;
  result_t [2:0] ent_r, ent_nxt;
  logic          xfer;

  assign xfer     = out_if.valid && out_if.ready;
  assign can_load = (num_r == 2'd0) || (num_r == 2'd1 && out_if.ready);

  assign out_if.valid       = num_r != 2'd0;
  assign out_if.out_byte    = ent_r[0].out_byte;
  assign out_if.status      = ent_r[0].status;
  assign out_if.out_count   = ent_r[0].out_count;
  assign out_if.last_of_run = ent_r[0].last_of_run;

  always_comb begin
    num_nxt = num_r;
    ent_nxt = ent_r;
    if (load) begin
      num_nxt = bundle.num;
      ent_nxt = bundle.entry;
    end else if (xfer) begin
      num_nxt    = num_r - 2'd1;
      ent_nxt[0] = ent_r[1];
      ent_nxt[1] = ent_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r <= 2'd0;
    end else begin
      num_r <= num_nxt;
    end
    ent_r <= ent_nxt;
  end

endmodule

@@ rtl/core/percent_url_decoder.sv @@
// channel   role    payload                                     transfer
// in_if     sink    in_byte[7:0], end_of_string                 valid & ready
// out_if    source  out_byte[7:0], status[1:0], out_count[15:0],
//                   last_of_run                                 valid & ready
// cfg_*     write   cfg_data[15:0] -> out_capacity              cfg_we
//
// One byte item is taken per cycle; its results land in the result register
// the next cycle. An end item yields up to three results, shifted out one a
// cycle, so input ready drops until the last of them transfers.
// Reset (rst_n low, synchronous) empties the result register, clears the
// decode state and sets out_capacity to 256. An output stall holds the
// result register; input is taken again once one result is left and moving.
module percent_url_decoder #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  pud_in_if.sink      in_if,
  pud_out_if.source   out_if
);
  import pud_pkg::*;

  bundle_t bundle;
  logic    can_load;
  logic    fire;

  assign in_if.ready = can_load;
  assign fire        = in_if.valid && can_load;

  pud_decode #(
    .COUNT_BITS(COUNT_BITS)
  ) u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .fire         (fire),
    .in_byte      (in_if.in_byte),
    .end_of_string(in_if.end_of_string),
    .bundle       (bundle)
  );

  pud_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (fire),
    .bundle  (bundle),
    .can_load(can_load),
    .out_if  (out_if)
  );

endmodule
